// ----- src/rcfv_pkg.sv -----
package rcfv_pkg;

  // Bytes per frame, counted from reset with no resynchronization.
  localparam int FRAME_BYTES = 18;
  // Only the leading bytes of a frame carry fields that are kept.
  localparam int STORED_BYTES = 16;
  localparam int POS_W = $clog2(FRAME_BYTES);

  localparam int CH_W = 11;
  localparam int SPEED_W = 8;
  localparam int SPEED_LIMIT = 110;

  // Division by six: floor(a / 6) == (a * DIV6_RECIP) >> DIV6_SHIFT for every 11-bit a.
  localparam int DIV6_RECIP = 43691;
  localparam int DIV6_SHIFT = 18;
  localparam int RECIP_W = 16;
  localparam int PROD_W = CH_W + RECIP_W;

  localparam logic [CH_W-1:0] CENTER_RESET = CH_W'(1024);
  localparam logic [CH_W-1:0] MINIMUM_RESET = CH_W'(364);
  localparam logic [CH_W-1:0] MAXIMUM_RESET = CH_W'(1684);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_CENTER  = 2'd0,
    REG_MINIMUM = 2'd1,
    REG_MAXIMUM = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic [CH_W-1:0] center;
    logic [CH_W-1:0] minimum;
    logic [CH_W-1:0] maximum;
  } cfg_t;

  typedef logic [STORED_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic last;  // position points at the final byte of the frame
    logic done;  // frame completed on the previous accepted byte
  } frame_status_t;

  typedef struct packed {
    logic                      in_band;
    logic signed [SPEED_W-1:0] speed;
  } stick_t;

endpackage

// ----- src/rcfv_regs.sv -----
module rcfv_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rcfv_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [rcfv_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [rcfv_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  output rcfv_pkg::cfg_t                        cfg_o
);

  rcfv_pkg::cfg_t cfg_q;
  logic [1:0]     index;
  logic           wr_en;

  assign index  = paddr[3:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center  <= rcfv_pkg::CENTER_RESET;
      cfg_q.minimum <= rcfv_pkg::MINIMUM_RESET;
      cfg_q.maximum <= rcfv_pkg::MAXIMUM_RESET;
    end else if (wr_en) begin
      unique case (index)
        rcfv_pkg::REG_CENTER:  cfg_q.center  <= pwdata[rcfv_pkg::CH_W-1:0];
        rcfv_pkg::REG_MINIMUM: cfg_q.minimum <= pwdata[rcfv_pkg::CH_W-1:0];
        rcfv_pkg::REG_MAXIMUM: cfg_q.maximum <= pwdata[rcfv_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      rcfv_pkg::REG_CENTER:  prdata = rcfv_pkg::APB_DATA_W'(cfg_q.center);
      rcfv_pkg::REG_MINIMUM: prdata = rcfv_pkg::APB_DATA_W'(cfg_q.minimum);
      rcfv_pkg::REG_MAXIMUM: prdata = rcfv_pkg::APB_DATA_W'(cfg_q.maximum);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/rcfv_frame.sv -----
module rcfv_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  output rcfv_pkg::frame_t      frame_o,
  output rcfv_pkg::frame_status_t status_o
);

  localparam logic [rcfv_pkg::POS_W-1:0] LastPos =
    rcfv_pkg::POS_W'(rcfv_pkg::FRAME_BYTES - 1);

  logic [rcfv_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       done_q;
  logic                       last;
  rcfv_pkg::frame_t           store_q;

  assign last  = (pos_q == LastPos);
  assign pos_d = last ? '0 : pos_q + rcfv_pkg::POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept_i && last;
      if (accept_i) begin
        pos_q <= pos_d;
      end
    end
  end

  // Bytes beyond the stored part of the frame are counted but dropped.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < rcfv_pkg::STORED_BYTES; i++) begin
      if (accept_i && (pos_q == rcfv_pkg::POS_W'(i))) begin
        store_q[i] <= rx_byte_i;
      end
    end
  end

  assign frame_o       = store_q;
  assign status_o.last = last;
  assign status_o.done = done_q;

endmodule

// ----- src/rcfv_stick.sv -----
module rcfv_stick (
  input  logic [rcfv_pkg::CH_W-1:0] ch_i,
  input  rcfv_pkg::cfg_t            cfg_i,
  output rcfv_pkg::stick_t          stick_o
);

  localparam int DiffW = rcfv_pkg::CH_W + 1;

  logic signed [DiffW-1:0]          diff;
  logic [rcfv_pkg::CH_W-1:0]        mag;
  logic [rcfv_pkg::PROD_W-1:0]      prod;
  logic [rcfv_pkg::PROD_W-rcfv_pkg::DIV6_SHIFT-1:0] quot;
  logic [rcfv_pkg::SPEED_W-1:0]     sat;
  logic                             low_band;
  logic                             high_band;

  assign low_band  = (ch_i >= cfg_i.minimum) && (ch_i < cfg_i.center);
  assign high_band = (ch_i > cfg_i.center) && (ch_i <= cfg_i.maximum);

  assign diff = $signed({1'b0, cfg_i.center}) - $signed({1'b0, ch_i});
  assign mag  = diff[DiffW-1] ? rcfv_pkg::CH_W'(-diff) : rcfv_pkg::CH_W'(diff);

  // Divide the magnitude so that the quotient truncates toward zero.
  assign prod = rcfv_pkg::PROD_W'(mag) * rcfv_pkg::PROD_W'(rcfv_pkg::DIV6_RECIP);
  assign quot = prod[rcfv_pkg::PROD_W-1:rcfv_pkg::DIV6_SHIFT];

  assign sat = (quot > $bits(quot)'(rcfv_pkg::SPEED_LIMIT)) ?
               rcfv_pkg::SPEED_W'(rcfv_pkg::SPEED_LIMIT) : rcfv_pkg::SPEED_W'(quot);

  assign stick_o.in_band = low_band || high_band;
  assign stick_o.speed   = diff[DiffW-1] ? $signed(-sat) : $signed(sat);

endmodule

// ----- src/rc_frame_to_chassis_velocity_core.sv -----
// Remote-control frame unpacker with stick-to-velocity mapping. Received bytes are
// accepted one per clock and counted into fixed frames of FRAME_BYTES bytes from reset,
// with no resynchronization; the first sixteen bytes of each frame are kept in a byte
// register file. After the last byte of a frame is accepted, a single registered request
// appears on the output channel carrying the three held velocities (forward from
// channel 2, lateral from channel 3 negated, spin from channel 0, each (center - ch) / 6
// truncated toward zero and limited to +/-110), the two switches, the mouse axes and
// buttons, and the key word. A stick inside its accepted band but off center updates its
// velocity, a stick out of band or at center keeps it, and all three at center clears
// all three. The sustained rate is one byte per cycle; the only stall comes from the
// single result register, which holds off the final byte of the next frame while the
// previous result is still waiting to be taken. The three stick registers are written
// through the APB port at byte offsets 0 (center), 4 (minimum) and 8 (maximum), should
// be changed only while the block is idle, and read back their current values.
module rc_frame_to_chassis_velocity_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcfv_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rcfv_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rcfv_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      rx_byte_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [7:0]               forward_speed_o,
  output logic signed [7:0]               lateral_speed_o,
  output logic signed [7:0]               spin_speed_o,
  output logic [1:0]                      left_switch_o,
  output logic [1:0]                      right_switch_o,
  output logic signed [15:0]              mouse_x_o,
  output logic signed [15:0]              mouse_y_o,
  output logic signed [15:0]              mouse_z_o,
  output logic [7:0]                      mouse_left_press_o,
  output logic [7:0]                      mouse_right_press_o,
  output logic [15:0]                     key_bits_o
);

  rcfv_pkg::cfg_t          cfg;
  rcfv_pkg::frame_t        frame;
  rcfv_pkg::frame_status_t status;
  logic                    in_accept;

  rcfv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The result register is loaded from the registered done flag, so the last byte may
  // only enter when the register is empty or is being emptied at the same edge.
  assign in_stall_o = status.last && out_valid_o && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  rcfv_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .frame_o   (frame),
    .status_o  (status)
  );

  // Stick channels are packed 11 bits each, least significant bit first.
  logic [rcfv_pkg::CH_W-1:0] ch0, ch2, ch3;

  assign ch0 = {frame[1][2:0], frame[0]};
  assign ch2 = {frame[4][0], frame[3], frame[2][7:6]};
  assign ch3 = {frame[5][3:0], frame[4][7:1]};

  rcfv_pkg::stick_t stick_fwd, stick_lat, stick_spin;

  rcfv_stick u_stick_fwd  (.ch_i(ch2), .cfg_i(cfg), .stick_o(stick_fwd));
  rcfv_stick u_stick_lat  (.ch_i(ch3), .cfg_i(cfg), .stick_o(stick_lat));
  rcfv_stick u_stick_spin (.ch_i(ch0), .cfg_i(cfg), .stick_o(stick_spin));

  // Held velocities carry over from frame to frame.
  logic signed [7:0] held_fwd_q, held_fwd_d;
  logic signed [7:0] held_lat_q, held_lat_d;
  logic signed [7:0] held_spin_q, held_spin_d;
  logic              all_center;

  assign all_center = (ch0 == cfg.center) && (ch2 == cfg.center) && (ch3 == cfg.center);

  always_comb begin
    held_fwd_d  = stick_fwd.in_band  ? stick_fwd.speed    : held_fwd_q;
    held_lat_d  = stick_lat.in_band  ? -stick_lat.speed   : held_lat_q;
    held_spin_d = stick_spin.in_band ? stick_spin.speed   : held_spin_q;
    if (all_center) begin
      held_fwd_d  = '0;
      held_lat_d  = '0;
      held_spin_d = '0;
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_fwd_q  <= '0;
      held_lat_q  <= '0;
      held_spin_q <= '0;
    end else begin
      if (status.done) begin
        out_valid_q <= 1'b1;
        held_fwd_q  <= held_fwd_d;
        held_lat_q  <= held_lat_d;
        held_spin_q <= held_spin_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The pass-through fields are captured from the store when the frame completes.
  logic [1:0]  left_sw_q, right_sw_q;
  logic [15:0] mouse_x_q, mouse_y_q, mouse_z_q, key_q;
  logic [7:0]  left_press_q, right_press_q;

  always_ff @(posedge clk_i) begin
    if (status.done) begin
      left_sw_q     <= frame[5][7:6];
      right_sw_q    <= frame[5][5:4];
      mouse_x_q     <= {frame[7], frame[6]};
      mouse_y_q     <= {frame[9], frame[8]};
      mouse_z_q     <= {frame[11], frame[10]};
      left_press_q  <= frame[12];
      right_press_q <= frame[13];
      key_q         <= {frame[15], frame[14]};
    end
  end

  assign out_valid_o         = out_valid_q;
  assign forward_speed_o     = held_fwd_q;
  assign lateral_speed_o     = held_lat_q;
  assign spin_speed_o        = held_spin_q;
  assign left_switch_o       = left_sw_q;
  assign right_switch_o      = right_sw_q;
  assign mouse_x_o           = $signed(mouse_x_q);
  assign mouse_y_o           = $signed(mouse_y_q);
  assign mouse_z_o           = $signed(mouse_z_q);
  assign mouse_left_press_o  = left_press_q;
  assign mouse_right_press_o = right_press_q;
  assign key_bits_o          = key_q;

endmodule

// ----- src/rcfv_checker.sv -----
module rcfv_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [rcfv_pkg::APB_ADDR_W-1:0] paddr,
  input logic [rcfv_pkg::APB_DATA_W-1:0] pwdata,
  input logic [rcfv_pkg::APB_DATA_W-1:0] prdata,
  input logic                            pready,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [7:0]               forward_speed_o,
  input logic signed [7:0]               lateral_speed_o,
  input logic signed [7:0]               spin_speed_o
);

  logic wr_center;

  assign wr_center = psel && penable && pwrite && pready &&
                     (paddr[3:2] == rcfv_pkg::REG_CENTER);

  // A waiting result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The input side is held off only by a result that is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // Velocities on an offered result never leave the saturated range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (forward_speed_o >= -8'sd110) && (forward_speed_o <= 8'sd110) &&
                    (lateral_speed_o >= -8'sd110) && (lateral_speed_o <= 8'sd110) &&
                    (spin_speed_o >= -8'sd110) && (spin_speed_o <= 8'sd110))
    else $error("velocity out of range");

  // A center write reads back on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_center ##1 (paddr[3:2] == rcfv_pkg::REG_CENTER) |->
      prdata[rcfv_pkg::CH_W-1:0] == $past(pwdata[rcfv_pkg::CH_W-1:0]))
    else $error("center register readback mismatch");

endmodule

bind rc_frame_to_chassis_velocity_core rcfv_checker u_rcfv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .pready          (pready),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .forward_speed_o (forward_speed_o),
  .lateral_speed_o (lateral_speed_o),
  .spin_speed_o    (spin_speed_o)
);
